FILE: sv/assert_macros.svh
// Assertion macros used by the list store RTL.
// Depends on nothing; each user provides clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ILS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ILS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ils_pkg.sv
// Shared codes and types for the indexed list store.
// Used by ils_cell and indexed_list_store; depends on nothing.
package ils_pkg;

    // Request operation codes
    localparam logic [2:0] OP_READ      = 3'd0;
    localparam logic [2:0] OP_OVERWRITE = 3'd1;
    localparam logic [2:0] OP_APPEND    = 3'd2;
    localparam logic [2:0] OP_INSERT    = 3'd3;
    localparam logic [2:0] OP_REMOVE    = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INDEX = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // Port widths fixed by the request and result fields
    localparam int unsigned IDX_W   = 6;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned OP_W    = 3;

    // Operation strobes broadcast to every cell of the row
    typedef struct packed {
        logic overwrite;
        logic append;
        logic insert;
        logic remove;
    } cell_ops_t;

endpackage

FILE: sv/indexed_list_store.sv
// Ordered list of up to CAPACITY words held in a row of cells. A request is first
// captured into the command register; then, in the execute step, every cell shifts,
// writes or holds at once and the result is loaded into the output register. A new
// request is accepted only once the previous one has executed; a stalled result holds
// the execute step. Reads and removals return the word through an OR of the cell
// taps. No clearing is done after reset: the list starts empty.
`include "assert_macros.svh"

module indexed_list_store #(
    parameter int unsigned CAPACITY   = 64,
    parameter int unsigned WORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ils_pkg::OP_W-1:0]      op,
    input  logic [ils_pkg::IDX_W-1:0]     index,
    input  logic [ils_pkg::VALUE_W-1:0]   value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ils_pkg::VALUE_W-1:0]   read_value,
    output logic [ils_pkg::COUNT_W-1:0]   count,
    output logic [1:0]                    status
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned CMP_W = ((CNT_W > ils_pkg::IDX_W) ? CNT_W : ils_pkg::IDX_W) + 1;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t                       state_reg, state_next;
    logic [ils_pkg::OP_W-1:0]     cmd_op_reg;
    logic [ils_pkg::IDX_W-1:0]    cmd_idx_reg;
    logic [WORD_WIDTH-1:0]        cmd_word_reg;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;

    logic                         out_valid_reg, out_valid_next;
    logic [ils_pkg::VALUE_W-1:0]  out_value_reg;
    logic [ils_pkg::COUNT_W-1:0]  out_count_reg;
    logic [1:0]                   out_status_reg;

    logic                         in_fire;
    logic                         exec_fire;
    logic [WORD_WIDTH-1:0]        in_word;
    logic [CMP_W-1:0]             idx_ext;
    logic [CMP_W-1:0]             cnt_ext;
    ils_pkg::cell_ops_t           ops_c;
    ils_pkg::cell_ops_t           cell_ops;
    logic [1:0]                   status_c;
    logic                         rd_sel;
    logic [WORD_WIDTH-1:0]        rd_word;
    logic [ils_pkg::VALUE_W-1:0]  rd_ext;
    logic [ils_pkg::COUNT_W-1:0]  cnt_out;

    logic [WORD_WIDTH-1:0]        cell_word [CAPACITY];
    logic [WORD_WIDTH-1:0]        cell_tap  [CAPACITY];

    // Handshake
    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign exec_fire = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);

    // Fit the request word to the stored width and the stored word to the result width
    generate
        if (WORD_WIDTH <= ils_pkg::VALUE_W)
        begin : g_narrow
            assign in_word = value[WORD_WIDTH-1:0];
            assign rd_ext  = ils_pkg::VALUE_W'(rd_word);
        end
        else
        begin : g_wide
            assign in_word = WORD_WIDTH'(value);
            assign rd_ext  = rd_word[ils_pkg::VALUE_W-1:0];
        end
    endgenerate

    // Sequence: capture, then execute once the output register is free
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_op_reg   <= op;
            cmd_idx_reg  <= index;
            cmd_word_reg <= in_word;
        end
    end

    // Check bounds and decide the operation
    assign idx_ext = CMP_W'(cmd_idx_reg);
    assign cnt_ext = CMP_W'(cnt_reg);

    always_comb
    begin
        status_c = ils_pkg::ST_OK;
        ops_c    = '0;
        rd_sel   = 1'b0;
        case (cmd_op_reg)
            ils_pkg::OP_READ:
            begin
                if (idx_ext < cnt_ext)
                begin
                    rd_sel = 1'b1;
                end
                else
                begin
                    status_c = ils_pkg::ST_INDEX;
                end
            end
            ils_pkg::OP_OVERWRITE:
            begin
                if (idx_ext < cnt_ext)
                begin
                    ops_c.overwrite = 1'b1;
                end
                else
                begin
                    status_c = ils_pkg::ST_INDEX;
                end
            end
            ils_pkg::OP_APPEND:
            begin
                if (cnt_reg == CAP_CNT)
                begin
                    status_c = ils_pkg::ST_FULL;
                end
                else
                begin
                    ops_c.append = 1'b1;
                end
            end
            ils_pkg::OP_INSERT:
            begin
                if (cnt_reg == CAP_CNT)
                begin
                    status_c = ils_pkg::ST_FULL;
                end
                else if (idx_ext > cnt_ext)
                begin
                    status_c = ils_pkg::ST_INDEX;
                end
                else
                begin
                    ops_c.insert = 1'b1;
                end
            end
            ils_pkg::OP_REMOVE:
            begin
                if (cnt_reg == '0)
                begin
                    status_c = ils_pkg::ST_EMPTY;
                end
                else if (idx_ext >= cnt_ext)
                begin
                    status_c = ils_pkg::ST_INDEX;
                end
                else
                begin
                    ops_c.remove = 1'b1;
                    rd_sel       = 1'b1;
                end
            end
            default:
            begin
                status_c = ils_pkg::ST_OK;
            end
        endcase
    end

    assign cell_ops = exec_fire ? ops_c : '0;

    // Advance the length
    always_comb
    begin
        cnt_next = cnt_reg;
        if (ops_c.append || ops_c.insert)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (ops_c.remove)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    generate
        if (CNT_W >= ils_pkg::COUNT_W)
        begin : g_cnt_trunc
            assign cnt_out = cnt_next[ils_pkg::COUNT_W-1:0];
        end
        else
        begin : g_cnt_ext
            assign cnt_out = ils_pkg::COUNT_W'(cnt_next);
        end
    endgenerate

    // Row of cells
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [WORD_WIDTH-1:0] left_w;
            logic [WORD_WIDTH-1:0] right_w;

            if (gi == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_mid_l
                assign left_w = cell_word[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_w = cell_word[gi];
            end
            else
            begin : g_mid_r
                assign right_w = cell_word[gi+1];
            end

            ils_cell #(
                .WORD_WIDTH (WORD_WIDTH),
                .CMP_W      (CMP_W),
                .POS        (gi)
            ) u_cell (
                .clk        (clk),
                .ops        (cell_ops),
                .idx        (idx_ext),
                .cnt        (cnt_ext),
                .new_word   (cmd_word_reg),
                .left_word  (left_w),
                .right_word (right_w),
                .word       (cell_word[gi]),
                .tap_word   (cell_tap[gi])
            );
        end
    endgenerate

    // Merge the cell taps; only the addressed cell drives a nonzero word
    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_word = rd_word | cell_tap[i];
        end
    end

    // Output register: load on execute, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            out_value_reg  <= rd_sel ? rd_ext : '0;
            out_count_reg  <= cnt_out;
            out_status_reg <= status_c;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (exec_fire)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = out_value_reg;
    assign count      = out_count_reg;
    assign status     = out_status_reg;

    // Checks
    `ILS_ASSERT_SAME(a_cnt_cap, 1'b1, cnt_reg <= CAP_CNT, "length above capacity")
    `ILS_ASSERT_NEXT(a_cnt_hold, !exec_fire, $stable(cnt_reg), "length moved without execute")
    `ILS_ASSERT_SAME(a_out_src, $rose(out_valid_reg), $past(exec_fire), "result without execute")
    `ILS_ASSERT_SAME(a_err_zero, out_valid_reg && (out_status_reg != ils_pkg::ST_OK), out_value_reg == '0, "error result carries a word")
    `ILS_ASSERT_SAME(a_empty_cnt, out_valid_reg && (out_status_reg == ils_pkg::ST_EMPTY), out_count_reg == '0, "empty status with nonzero length")

endmodule

FILE: sv/ils_cell.sv
// One storage cell of the list row: holds the word at a fixed position.
// Depends on ils_pkg for the broadcast operation strobes.
module ils_cell #(
    parameter int unsigned WORD_WIDTH = 32,
    parameter int unsigned CMP_W      = 8,
    parameter int unsigned POS        = 0
) (
    input  logic                  clk,
    input  ils_pkg::cell_ops_t    ops,
    input  logic [CMP_W-1:0]      idx,
    input  logic [CMP_W-1:0]      cnt,
    input  logic [WORD_WIDTH-1:0] new_word,
    input  logic [WORD_WIDTH-1:0] left_word,
    input  logic [WORD_WIDTH-1:0] right_word,
    output logic [WORD_WIDTH-1:0] word,
    output logic [WORD_WIDTH-1:0] tap_word
);

    localparam logic [CMP_W-1:0] MY_POS  = CMP_W'(POS);
    localparam logic [CMP_W-1:0] NXT_POS = CMP_W'(POS + 1);

    logic [WORD_WIDTH-1:0] word_reg;
    logic [WORD_WIDTH-1:0] word_next;

    // Pick the new content: write in place, take from left on insert, from right on remove
    always_comb
    begin
        word_next = word_reg;
        priority if (ops.overwrite && (idx == MY_POS))
        begin
            word_next = new_word;
        end
        else if (ops.append && (cnt == MY_POS))
        begin
            word_next = new_word;
        end
        else if (ops.insert && (idx == MY_POS))
        begin
            word_next = new_word;
        end
        else if (ops.insert && (MY_POS > idx) && (MY_POS <= cnt))
        begin
            word_next = left_word;
        end
        else if (ops.remove && (MY_POS >= idx) && (NXT_POS < cnt))
        begin
            word_next = right_word;
        end
        else
        begin
            word_next = word_reg;
        end
    end

    // Hold the word
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word     = word_reg;
    assign tap_word = (idx == MY_POS) ? word_reg : '0;

endmodule

FILE: dv/tb_indexed_list_store.sv
// Self-checking testbench for indexed_list_store: a queued driver, a checking monitor
// and a shadow list that predicts every reply. Depends on ils_pkg and the RTL only.
module tb_indexed_list_store;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH  = 64;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PRINT_LIMIT = 40;

    typedef struct {
        logic [ils_pkg::OP_W-1:0]    op;
        logic [ils_pkg::IDX_W-1:0]   idx;
        logic [ils_pkg::VALUE_W-1:0] val;
        int                          gap;
        bit                          drain;
    } list_request_t;

    typedef struct {
        logic [ils_pkg::VALUE_W-1:0] word;
        logic [ils_pkg::COUNT_W-1:0] len;
        logic [1:0]                  st;
    } list_reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [ils_pkg::OP_W-1:0]    op = '0;
    logic [ils_pkg::IDX_W-1:0]   index = '0;
    logic [ils_pkg::VALUE_W-1:0] value = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [ils_pkg::VALUE_W-1:0] read_value;
    logic [ils_pkg::COUNT_W-1:0] count;
    logic [1:0]                  status;

    indexed_list_store dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .index      (index),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_value (read_value),
        .count      (count),
        .status     (status)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow list state and bookkeeping
    logic [ils_pkg::VALUE_W-1:0] shadow_words [LIST_DEPTH];
    int                 shadow_len = 0;
    int                 peak_len = 0;
    list_request_t      pending_requests [$];
    list_reply_t        expected_replies [$];
    int                 plan_len = 0;
    int                 n_sent = 0;
    int                 n_done = 0;
    int                 error_count = 0;
    int                 cycle_count = 0;
    int                 op_hits [8];
    int                 status_hits [4];

    // Report one mismatch and count it
    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        if (error_count < PRINT_LIMIT)
        begin
            $display("MISMATCH at result %0d: %s expected 0x%0h got 0x%0h",
                     n_done, what, want, got);
        end
        error_count++;
    endtask

    // Apply one request to the shadow list and return the reply it should produce
    function automatic list_reply_t apply_request(input logic [ils_pkg::OP_W-1:0] rop,
                                                  input logic [ils_pkg::IDX_W-1:0] ridx,
                                                  input logic [ils_pkg::VALUE_W-1:0] rval);
        list_reply_t r;
        int          k;
        int          pos;
        r.word = '0;
        r.st   = ils_pkg::ST_OK;
        pos    = int'(ridx);
        case (rop)
            ils_pkg::OP_READ:
            begin
                if (pos < shadow_len)
                    r.word = shadow_words[pos];
                else
                    r.st = ils_pkg::ST_INDEX;
            end
            ils_pkg::OP_OVERWRITE:
            begin
                if (pos < shadow_len)
                    shadow_words[pos] = rval;
                else
                    r.st = ils_pkg::ST_INDEX;
            end
            ils_pkg::OP_APPEND:
            begin
                if (shadow_len >= LIST_DEPTH)
                    r.st = ils_pkg::ST_FULL;
                else
                begin
                    shadow_words[shadow_len] = rval;
                    shadow_len++;
                end
            end
            ils_pkg::OP_INSERT:
            begin
                // full check wins over the index check
                if (shadow_len >= LIST_DEPTH)
                    r.st = ils_pkg::ST_FULL;
                else if (pos > shadow_len)
                    r.st = ils_pkg::ST_INDEX;
                else
                begin
                    for (k = shadow_len; k > pos; k--)
                        shadow_words[k] = shadow_words[k - 1];
                    shadow_words[pos] = rval;
                    shadow_len++;
                end
            end
            ils_pkg::OP_REMOVE:
            begin
                // empty check wins over the index check
                if (shadow_len == 0)
                    r.st = ils_pkg::ST_EMPTY;
                else if (pos >= shadow_len)
                    r.st = ils_pkg::ST_INDEX;
                else
                begin
                    r.word = shadow_words[pos];
                    for (k = pos; k + 1 < shadow_len; k++)
                        shadow_words[k] = shadow_words[k + 1];
                    shadow_len--;
                end
            end
            default:
            begin
            end
        endcase
        if (shadow_len > peak_len)
            peak_len = shadow_len;
        r.len = shadow_len[ils_pkg::COUNT_W-1:0];
        return r;
    endfunction

    // Queue one request and track the list length the plan leads to
    task automatic queue_request(input logic [ils_pkg::OP_W-1:0] o, input int i,
                                 input logic [ils_pkg::VALUE_W-1:0] v, input int gap,
                                 input bit drain);
        list_request_t req;
        req.op    = o;
        req.idx   = i[ils_pkg::IDX_W-1:0];
        req.val   = v;
        req.gap   = gap;
        req.drain = drain;
        pending_requests.push_back(req);
        case (o)
            ils_pkg::OP_APPEND:
            begin
                if (plan_len < LIST_DEPTH)
                    plan_len++;
            end
            ils_pkg::OP_INSERT:
            begin
                if (plan_len < LIST_DEPTH && i <= plan_len)
                    plan_len++;
            end
            ils_pkg::OP_REMOVE:
            begin
                if (plan_len > 0 && i < plan_len)
                    plan_len--;
            end
            default:
            begin
            end
        endcase
    endtask

    // Driver: present queued transactions, predict each one as it is accepted
    list_request_t cur_req;
    bit            have_cur = 1'b0;
    int            wait_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            op       <= '0;
            index    <= '0;
            value    <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_replies.push_back(apply_request(op, index, value));
                op_hits[op]++;
                n_sent++;
            end
            // hold a stalled transaction, otherwise load the next one
            if (!(in_valid && in_stall))
            begin
                if (!have_cur && pending_requests.size() > 0)
                begin
                    cur_req   = pending_requests.pop_front();
                    have_cur  = 1'b1;
                    wait_left = cur_req.gap;
                end
                if (have_cur && wait_left == 0 && (!cur_req.drain || n_sent == n_done))
                begin
                    in_valid <= 1'b1;
                    op       <= cur_req.op;
                    index    <= cur_req.idx;
                    value    <= cur_req.val;
                    have_cur = 1'b0;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (have_cur && wait_left > 0)
                        wait_left--;
                end
            end
        end
    end

    // Monitor: compare each accepted reply with the oldest prediction
    list_reply_t want;
    int          stall_left = 0;
    bit          calm_mode = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            n_done    <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_replies.size() == 0)
                    report_mismatch("unexpected result", 64'd0, {32'd0, read_value});
                else
                begin
                    want = expected_replies.pop_front();
                    if (read_value !== want.word)
                        report_mismatch("read_value", want.word, read_value);
                    if (count !== want.len)
                        report_mismatch("count", want.len, count);
                    if (status !== want.st)
                        report_mismatch("status", want.st, status);
                    status_hits[want.st]++;
                end
                n_done <= n_done + 1;
                // switch between calm and stalling stretches now and then
                if ((n_done % 64) == 0)
                    calm_mode = ($urandom_range(0, 9) < 3);
                stall_left = calm_mode ? 0 : $urandom_range(0, 10);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_replies.size());
            $display("tb_indexed_list_store NOT OK");
            $finish;
        end
    end

    // Build the stimulus, run it and judge the outcome
    initial
    begin
        int  n;
        int  r;
        int  sel_op;
        int  pos;
        int  gap;
        int  burst_gap0;
        bit  grow;
        logic [ils_pkg::VALUE_W-1:0] v;

        // directed: empty list, edges of the index range, both ends, unused codes
        queue_request(ils_pkg::OP_READ,      0,  32'h1234_5678, 0, 1'b0);
        queue_request(ils_pkg::OP_REMOVE,    0,  32'h0,         1, 1'b0);
        queue_request(ils_pkg::OP_OVERWRITE, 0,  32'hDEAD_BEEF, 0, 1'b0);
        queue_request(ils_pkg::OP_INSERT,    1,  32'h1111_1111, 2, 1'b0);
        queue_request(ils_pkg::OP_INSERT,    0,  32'hFFFF_FFFF, 0, 1'b0);
        queue_request(ils_pkg::OP_APPEND,    63, 32'h0000_0000, 0, 1'b0);
        queue_request(ils_pkg::OP_INSERT,    2,  32'hA5A5_A5A5, 3, 1'b0);
        queue_request(ils_pkg::OP_INSERT,    0,  32'h5A5A_5A5A, 0, 1'b0);
        queue_request(ils_pkg::OP_READ,      0,  32'h0,         0, 1'b0);
        queue_request(ils_pkg::OP_READ,      3,  32'h0,         0, 1'b0);
        queue_request(ils_pkg::OP_READ,      4,  32'h0,         1, 1'b0);
        queue_request(ils_pkg::OP_READ,      63, 32'hFFFF_FFFF, 0, 1'b0);
        queue_request(ils_pkg::OP_OVERWRITE, 2,  32'h8000_0000, 0, 1'b0);
        queue_request(ils_pkg::OP_READ,      2,  32'h0,         0, 1'b0);
        queue_request(ils_pkg::OP_OVERWRITE, 4,  32'h0000_0001, 0, 1'b0);
        queue_request(ils_pkg::OP_REMOVE,    4,  32'h0,         2, 1'b0);
        queue_request(ils_pkg::OP_REMOVE,    0,  32'h0,         0, 1'b0);
        queue_request(ils_pkg::OP_REMOVE,    2,  32'h0,         0, 1'b0);
        queue_request(3'd5,                  0,  32'h0,         0, 1'b0);
        queue_request(3'd6,                  21, 32'h5555_5555, 0, 1'b0);
        queue_request(3'd7,                  63, 32'hFFFF_FFFF, 0, 1'b0);
        queue_request(ils_pkg::OP_REMOVE,    63, 32'h0,         0, 1'b0);
        queue_request(ils_pkg::OP_INSERT,    63, 32'h7FFF_FFFF, 0, 1'b1);

        // random: alternate growing and shrinking phases so the list hits full and empty
        grow       = 1'b1;
        burst_gap0 = 0;
        for (n = 0; n < 1200; n++)
        begin
            if ((n % 150) == 0)
                grow = !grow || (n == 0);
            if ((n % 50) == 0)
                burst_gap0 = ($urandom_range(0, 9) < 3);
            r = $urandom_range(0, 99);
            if (grow)
                sel_op = (r < 35) ? ils_pkg::OP_APPEND :
                         (r < 65) ? ils_pkg::OP_INSERT :
                         (r < 75) ? ils_pkg::OP_READ :
                         (r < 85) ? ils_pkg::OP_OVERWRITE :
                         (r < 95) ? ils_pkg::OP_REMOVE : $urandom_range(5, 7);
            else
                sel_op = (r < 50) ? ils_pkg::OP_REMOVE :
                         (r < 65) ? ils_pkg::OP_READ :
                         (r < 80) ? ils_pkg::OP_OVERWRITE :
                         (r < 88) ? ils_pkg::OP_APPEND :
                         (r < 95) ? ils_pkg::OP_INSERT : $urandom_range(5, 7);
            // mostly legal positions, some anywhere in the field
            if ($urandom_range(0, 99) < 85)
            begin
                if (sel_op == ils_pkg::OP_INSERT)
                    pos = $urandom_range(0, (plan_len < 63) ? plan_len : 63);
                else if (plan_len > 0)
                    pos = $urandom_range(0, plan_len - 1);
                else
                    pos = $urandom_range(0, 63);
            end
            else
                pos = $urandom_range(0, 63);
            case ($urandom_range(0, 39))
                0:       v = 32'h0000_0000;
                1:       v = 32'hFFFF_FFFF;
                2:       v = 32'h8000_0000;
                3:       v = 32'h0000_0001;
                default: v = $urandom;
            endcase
            gap = burst_gap0 ? 0 : $urandom_range(0, 10);
            queue_request(sel_op[ils_pkg::OP_W-1:0], pos, v, gap, (n % 250) == 0);
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // wait for the queue and the pipeline to drain
        while (pending_requests.size() > 0 || have_cur || in_valid || n_done != n_sent)
            @(negedge clk);
        repeat (10) @(negedge clk);

        while (expected_replies.size() > 0)
        begin
            want = expected_replies.pop_front();
            report_mismatch("missing result, count", want.len, 64'd0);
        end

        $display("covered %0d requests: read %0d overwrite %0d append %0d insert %0d remove %0d",
                 n_sent, op_hits[ils_pkg::OP_READ], op_hits[ils_pkg::OP_OVERWRITE],
                 op_hits[ils_pkg::OP_APPEND], op_hits[ils_pkg::OP_INSERT],
                 op_hits[ils_pkg::OP_REMOVE]);
        $display("replies ok %0d index %0d full %0d empty %0d, peak length %0d, errors %0d",
                 status_hits[ils_pkg::ST_OK], status_hits[ils_pkg::ST_INDEX],
                 status_hits[ils_pkg::ST_FULL], status_hits[ils_pkg::ST_EMPTY],
                 peak_len, error_count);
        if (error_count == 0)
            $display("tb_indexed_list_store OK");
        else
            $display("tb_indexed_list_store NOT OK");
        $finish;
    end

endmodule
